>>> sv/acs_pkg.sv
// Shared types and constants for the accumulator step unit.
`timescale 1ns / 1ps

package acs_pkg;

    // Data memory geometry; addresses wrap by masking, so DATA_WORDS is a power of two.
    localparam int DATA_WORDS = 256;
    localparam int ADDR_W     = $clog2(DATA_WORDS);

    localparam int PC_W   = 16;
    localparam int ACC_W  = 32;
    localparam int OP_W   = 4;
    localparam int ARG_W  = 16;
    localparam int STAT_W = 2;

    // Opcodes; anything else is illegal.
    localparam logic [OP_W-1:0] OP_LDI = 4'd0;
    localparam logic [OP_W-1:0] OP_LD  = 4'd1;
    localparam logic [OP_W-1:0] OP_LDX = 4'd2;
    localparam logic [OP_W-1:0] OP_ST  = 4'd3;
    localparam logic [OP_W-1:0] OP_STX = 4'd4;
    localparam logic [OP_W-1:0] OP_ADD = 4'd5;
    localparam logic [OP_W-1:0] OP_NEG = 4'd6;
    localparam logic [OP_W-1:0] OP_BRZ = 4'd7;

    localparam logic KIND_EXEC   = 1'b0;
    localparam logic KIND_RETURN = 1'b1;

    localparam logic [STAT_W-1:0] ST_NORMAL  = 2'd0;
    localparam logic [STAT_W-1:0] ST_ILLEGAL = 2'd1;
    localparam logic [STAT_W-1:0] ST_MEMVIOL = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INDIRECT
    } acs_state_t;

    typedef struct packed {
        logic             kind;
        logic [OP_W-1:0]  opcode;
        logic [ARG_W-1:0] argument;
    } acs_in_t;

    typedef struct packed {
        logic [PC_W-1:0]         program_counter;
        logic signed [ACC_W-1:0] accumulator_value;
        logic [STAT_W-1:0]       interrupt_status;
    } acs_out_t;

    // Data memory request: one read port and one write port.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ACC_W-1:0]  wr_data;
    } acs_mem_req_t;

endpackage

>>> sv/accumulator_cpu_step_unit.sv
// Top level of the accumulator machine step unit.
`timescale 1ns / 1ps
// Flow: an accepted item waits in the input buffer; from idle the core takes it and
//   issues its direct operand read, then executes it, a load indirect adding a second
//   dependent read; the result is registered. A new item starts only from idle.
// Reset: pc, accumulator, status and program_size go to zero; memory words read
//   as zero until written (per-word valid bits), so no clearing pass is needed.

module accumulator_cpu_step_unit
    import acs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [PC_W-1:0]  cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  acs_in_t          in_item,
    output logic             out_valid,
    input  logic             out_stall,
    output acs_out_t         out_item
);

    // Architectural state
    logic [PC_W-1:0]   program_size_reg;
    logic [PC_W-1:0]   pc_reg,     pc_next;
    logic [ACC_W-1:0]  acc_reg,    acc_next;
    logic [STAT_W-1:0] status_reg, status_next;

    // Input buffer: lets the upstream side hand over an item while the core is busy.
    logic    ibuf_valid_reg;
    acs_in_t ibuf_reg;

    // Item in flight
    acs_in_t cur_reg;

    acs_state_t state_reg, state_next;

    // Result register
    logic     out_valid_reg;
    acs_out_t out_reg;

    logic             take;
    logic             done_ok;
    logic             finish;
    acs_mem_req_t     mem_req;
    logic [ACC_W-1:0] mem_data;

    acs_dmem u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (mem_data)
    );

    // Core pulls the buffered item only from idle, so it never sees a half-done write.
    assign take     = (state_reg == S_IDLE) && ibuf_valid_reg;
    assign in_stall = ibuf_valid_reg && !take;

    // A result may be produced when the output slot is free or draining this cycle.
    assign done_ok = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cur_reg.kind == KIND_EXEC && status_reg == ST_NORMAL &&
                    pc_reg < program_size_reg && cur_reg.opcode == OP_LDX)
                begin
                    state_next = S_INDIRECT;
                end
                else if (done_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            S_INDIRECT:
            begin
                if (done_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        logic jumped;
        jumped      = 1'b0;
        finish      = 1'b0;
        pc_next     = pc_reg;
        acc_next    = acc_reg;
        status_next = status_reg;
        mem_req     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Direct operand read issued as the item enters.
                mem_req.rd_en   = take;
                mem_req.rd_addr = ibuf_reg.argument[ADDR_W-1:0];
            end
            S_EXEC:
            begin
                if (cur_reg.kind == KIND_RETURN)
                begin
                    finish = done_ok;
                    if (status_reg != ST_NORMAL)
                    begin
                        status_next = ST_NORMAL;
                        pc_next     = pc_reg + PC_W'(1);
                    end
                end
                else if (status_reg != ST_NORMAL)
                begin
                    // Interrupt pending: execute steps are ignored.
                    finish = done_ok;
                end
                else if (pc_reg >= program_size_reg)
                begin
                    finish      = done_ok;
                    status_next = ST_MEMVIOL;
                end
                else if (cur_reg.opcode == OP_LDX)
                begin
                    // Pointer word is in; fetch the operand it names.
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = mem_data[ADDR_W-1:0];
                end
                else
                begin
                    finish = done_ok;
                    case (cur_reg.opcode)
                        OP_LDI: acc_next = ACC_W'(cur_reg.argument);
                        OP_LD:  acc_next = mem_data;
                        OP_ST:
                        begin
                            mem_req.wr_en   = done_ok;
                            mem_req.wr_addr = cur_reg.argument[ADDR_W-1:0];
                            mem_req.wr_data = acc_reg;
                        end
                        OP_STX:
                        begin
                            mem_req.wr_en   = done_ok;
                            mem_req.wr_addr = mem_data[ADDR_W-1:0];
                            mem_req.wr_data = acc_reg;
                        end
                        OP_ADD: acc_next = acc_reg + mem_data;
                        OP_NEG: acc_next = '0 - acc_reg;
                        OP_BRZ:
                        begin
                            if (acc_reg == '0)
                            begin
                                jumped  = 1'b1;
                                pc_next = cur_reg.argument;
                            end
                        end
                        default: status_next = ST_ILLEGAL;
                    endcase
                    if (status_next == ST_NORMAL && !jumped)
                    begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                end
            end
            S_INDIRECT:
            begin
                finish   = done_ok;
                acc_next = mem_data;
                pc_next  = pc_reg + PC_W'(1);
            end
            default:
            begin
                finish = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_size_reg <= '0;
            pc_reg           <= '0;
            acc_reg          <= '0;
            status_reg       <= ST_NORMAL;
            state_reg        <= S_IDLE;
            ibuf_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                program_size_reg <= cfg_wr_data;
            end

            if (in_valid && !in_stall)
            begin
                ibuf_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                ibuf_valid_reg <= 1'b0;
            end

            // Architectural state commits only with the result.
            if (finish)
            begin
                pc_reg        <= pc_next;
                acc_reg       <= acc_next;
                status_reg    <= status_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ibuf_reg <= in_item;
        end
        if (take)
        begin
            cur_reg <= ibuf_reg;
        end
        if (finish)
        begin
            out_reg.program_counter   <= pc_next;
            out_reg.accumulator_value <= $signed(acc_next);
            out_reg.interrupt_status  <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // Checks

    // The second read of a load indirect always follows its pointer read; the
    // indirect state may then hold while the output slot is blocked.
    a_indirect_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INDIRECT) |->
            ($past(state_reg) == S_EXEC || $past(state_reg) == S_INDIRECT))
        else $error("indirect state entered without a pointer read");

    // A new result never overwrites one still waiting downstream.
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (!out_valid_reg || !out_stall))
        else $error("result produced while output slot is blocked");

    // Memory is written only when a store commits.
    a_write_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (finish && state_reg == S_EXEC))
        else $error("data memory write outside store commit");

    // The core only picks up a buffered item, and never while one is in flight.
    a_take_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == S_EXEC && $past(ibuf_valid_reg)))
        else $error("item taken without entering execute");

endmodule

>>> sv/acs_dmem.sv
// Data memory with per-word valid bits so unwritten words read as zero.
`timescale 1ns / 1ps

module acs_dmem
    import acs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  acs_mem_req_t req,
    output logic [ACC_W-1:0] rd_data
);

    logic [ACC_W-1:0]      mem [DATA_WORDS];
    logic [DATA_WORDS-1:0] written_reg;
    logic [ACC_W-1:0]      rd_data_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                written_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= written_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the accumulator machine step unit.
`timescale 1ns / 1ps

module testbench
    import acs_pkg::*;
();

    localparam int LONG_HOLD     = 80;    // receiver hold-off used to fill the block
    localparam int SETTLE_CYCLES = 4;     // extra wait after the last result
    localparam int IDLE_LIMIT    = 2000;  // cycles with no item moving on either side
    localparam int MAX_PRINTS    = 100;

    // Tracks the architectural state of the core and the results it must produce.
    class step_checker;
        logic [PC_W-1:0]  pc;
        logic [ACC_W-1:0] acc;
        logic [STAT_W-1:0] status;
        logic [PC_W-1:0]  prog_size;
        logic [ACC_W-1:0] data_mem [DATA_WORDS];
        acs_out_t         expected_states [$];
        int               mismatches;

        function new();
            pc         = '0;
            acc        = '0;
            status     = ST_NORMAL;
            prog_size  = '0;
            mismatches = 0;
            foreach (data_mem[i])
                data_mem[i] = '0;
        endfunction

        function void set_program_size(input logic [PC_W-1:0] v);
            prog_size = v;
        endfunction

        function int pending();
            return expected_states.size();
        endfunction

        // Apply one accepted item and queue the state it leaves behind.
        function void note_step(input acs_in_t it);
            logic [ADDR_W-1:0] addr;
            logic [ADDR_W-1:0] ptr;
            logic              jumped;
            acs_out_t          e;
            addr   = it.argument[ADDR_W-1:0];
            ptr    = data_mem[addr][ADDR_W-1:0];
            jumped = 1'b0;
            if (it.kind == KIND_EXEC)
            begin
                if (status == ST_NORMAL)
                begin
                    if (pc < prog_size)
                    begin
                        case (it.opcode)
                            OP_LDI: acc = {{(ACC_W-ARG_W){1'b0}}, it.argument};
                            OP_LD:  acc = data_mem[addr];
                            OP_LDX: acc = data_mem[ptr];
                            OP_ST:  data_mem[addr] = acc;
                            OP_STX: data_mem[ptr] = acc;
                            OP_ADD: acc = acc + data_mem[addr];
                            OP_NEG: acc = -acc;
                            OP_BRZ:
                            begin
                                if (acc == '0)
                                begin
                                    pc     = it.argument;
                                    jumped = 1'b1;
                                end
                            end
                            default: status = ST_ILLEGAL;
                        endcase
                    end
                    else
                        status = ST_MEMVIOL;
                    if (status == ST_NORMAL && !jumped)
                        pc = pc + 1'b1;
                end
            end
            else if (status != ST_NORMAL)
            begin
                // return from interrupt: skip the faulting instruction
                status = ST_NORMAL;
                pc     = pc + 1'b1;
            end
            e.program_counter   = pc;
            e.accumulator_value = acc;
            e.interrupt_status  = status;
            expected_states.push_back(e);
        endfunction

        task report_mismatch(input string what, input logic [31:0] got,
                             input logic [31:0] want);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        endtask

        task check_result(input acs_out_t got);
            acs_out_t want;
            if (expected_states.size() == 0)
            begin
                report_mismatch("result with nothing outstanding", got.program_counter, '0);
                return;
            end
            want = expected_states.pop_front();
            if (got.program_counter !== want.program_counter)
                report_mismatch("program_counter", got.program_counter, want.program_counter);
            if (got.accumulator_value !== want.accumulator_value)
                report_mismatch("accumulator_value", got.accumulator_value,
                                want.accumulator_value);
            if (got.interrupt_status !== want.interrupt_status)
                report_mismatch("interrupt_status", got.interrupt_status,
                                want.interrupt_status);
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [PC_W-1:0]  cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    acs_in_t          in_item;
    logic             out_valid;
    logic             out_stall;
    acs_out_t         out_item;

    step_checker      sb;
    bit               no_idle  = 1'b0;  // both sides run back to back
    bit               hold_req = 1'b0;  // sender asks receiver for one long hold-off
    int               sent_count = 0;
    int               idle_cycles = 0;

    accumulator_cpu_step_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic acs_in_t make_step(input logic k, input logic [OP_W-1:0] op,
                                          input logic [ARG_W-1:0] arg);
        acs_in_t it;
        it.kind     = k;
        it.opcode   = op;
        it.argument = arg;
        return it;
    endfunction

    // Data address: usually a small hot set (with random alias bits above), else anything.
    function automatic logic [ARG_W-1:0] pick_addr();
        logic [ARG_W-1:0] a;
        a = ARG_W'($urandom);
        if ($urandom_range(0, 9) < 7)
            a[ADDR_W-1:0] = ADDR_W'($urandom_range(0, 7));
        return a;
    endfunction

    // Branch target: mostly inside the program so execution keeps going.
    function automatic logic [ARG_W-1:0] pick_target(input logic [PC_W-1:0] size);
        if (size == '0 || $urandom_range(0, 9) < 2)
            return ARG_W'($urandom);
        if (size > 16'd512)
            return ARG_W'($urandom_range(0, size - 1));
        return ARG_W'($urandom_range(0, (size - 1) / 2));
    endfunction

    // Monitor and watchdog. Everything is sampled on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_step(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin : receiver
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else
            begin
                n = idle_len();
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                out_stall <= 1'b0;
            end
        end
    end

    // Offer one item and hold it until the block takes it.
    task automatic send_item(input acs_in_t it);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
    endtask

    // Stop offering and wait until every result is back and the block is quiet.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write enable is raised and then dropped again, so back-to-back writes never collide.
    task automatic write_program_size(input logic [PC_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_program_size(v);
        @(posedge clk);
    endtask

    // Steer the core back to pc 0, status normal. Only called while idle, so the
    // tracked state is settled.
    task automatic rewind_pc();
        write_program_size(16'hFFFF);
        while (sb.pc != '0 || sb.status != ST_NORMAL)
        begin
            if (sb.status != ST_NORMAL)
                send_item(make_step(KIND_RETURN, OP_LDI, '0));
            else if (sb.acc != '0)
                send_item(make_step(KIND_EXEC, OP_LDI, '0));
            else
                send_item(make_step(KIND_EXEC, OP_BRZ, '0));
            wait_for_results();
        end
    endtask

    // Load a seed, negate it, double it by store/add pairs, then negate again and branch on zero.
    // Seed 0x8000 with 16 doublings lands on the most negative accumulator value.
    task automatic send_doubling_chain(input logic [ARG_W-1:0] seed, input int steps);
        logic [ARG_W-1:0] a;
        a = pick_addr();
        send_item(make_step(KIND_EXEC, OP_LDI, seed));
        send_item(make_step(KIND_EXEC, OP_NEG, ARG_W'($urandom)));
        for (int i = 0; i < steps; i++)
        begin
            send_item(make_step(KIND_EXEC, OP_ST, a));
            send_item(make_step(KIND_EXEC, OP_ADD, a));
        end
        send_item(make_step(KIND_EXEC, OP_NEG, ARG_W'($urandom)));
        send_item(make_step(KIND_EXEC, OP_BRZ, ARG_W'($urandom)));
    endtask

    // One short program fragment with random content, or a bit of noise.
    task automatic send_sequence(input logic [PC_W-1:0] size);
        int               roll;
        int               n;
        logic [ARG_W-1:0] a;
        logic [OP_W-1:0]  op;
        roll = $urandom_range(0, 99);
        if (roll < 30)
        begin
            send_item(make_step(KIND_EXEC, OP_LDI, ARG_W'($urandom)));
            n = $urandom_range(1, 5);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0:       op = OP_ST;
                    1:       op = OP_ADD;
                    2:       op = OP_NEG;
                    default: op = OP_LD;
                endcase
                send_item(make_step(KIND_EXEC, op, pick_addr()));
            end
        end
        else if (roll < 50)
        begin
            // pointer in memory, then store through it and load from or through it
            a = pick_addr();
            send_item(make_step(KIND_EXEC, OP_LDI, pick_addr()));
            send_item(make_step(KIND_EXEC, OP_ST, a));
            send_item(make_step(KIND_EXEC, OP_LDI, ARG_W'($urandom)));
            send_item(make_step(KIND_EXEC, OP_STX, a));
            send_item(make_step(KIND_EXEC, ($urandom_range(0, 1) != 0) ? OP_LDX : OP_LD,
                                ($urandom_range(0, 3) != 0) ? a : pick_addr()));
        end
        else if (roll < 65)
        begin
            send_item(make_step(KIND_EXEC, OP_LDI,
                                ($urandom_range(0, 4) != 0) ? '0 : ARG_W'($urandom)));
            send_item(make_step(KIND_EXEC, OP_BRZ, pick_target(size)));
        end
        else if (roll < 77)
        begin
            if ($urandom_range(0, 1) != 0)
                send_item(make_step(KIND_EXEC, OP_W'($urandom_range(8, 15)),
                                    ARG_W'($urandom)));
            send_item(make_step(KIND_RETURN, OP_W'($urandom), ARG_W'($urandom)));
        end
        else if (roll < 80)
            send_doubling_chain(ARG_W'($urandom), $urandom_range(1, 16));
        else
        begin
            n = $urandom_range(1, 3);
            repeat (n)
                send_item(make_step(1'($urandom), OP_W'($urandom), ARG_W'($urandom)));
        end
    endtask

    task automatic run_phase(input logic [PC_W-1:0] size, input int n_items,
                             input bit quiet, input bit squeeze);
        int first;
        if (size < 16'h0400)
            rewind_pc();   // small program: start from the top
        write_program_size(size);
        no_idle = quiet;
        first   = sent_count;
        if (squeeze)
            hold_req = 1'b1;
        while (sent_count - first < n_items)
            send_sequence(size);
        wait_for_results();
        no_idle = 1'b0;
    endtask

    task automatic run_directed();
        // program size is still 0 after reset
        send_item(make_step(KIND_EXEC, OP_LDI, 16'h1234));     // memory violation
        send_item(make_step(KIND_EXEC, OP_ADD, 16'h0005));     // ignored while pending
        send_item(make_step(KIND_RETURN, OP_LDI, '0));         // back to normal, pc 1
        send_item(make_step(KIND_RETURN, OP_LDI, '0));         // no effect when normal
        wait_for_results();
        write_program_size(16'hFFFF);
        send_item(make_step(KIND_EXEC, OP_LDI, 16'hFFFF));
        send_item(make_step(KIND_EXEC, OP_ST, 16'hFFFF));      // address wraps to 255
        send_item(make_step(KIND_EXEC, OP_LD, 16'h00FF));
        send_item(make_step(KIND_EXEC, OP_ADD, 16'hFFFF));
        send_item(make_step(KIND_EXEC, OP_NEG, '0));
        send_item(make_step(KIND_EXEC, OP_ST, 16'h0003));      // pointer with high bits set
        send_item(make_step(KIND_EXEC, OP_LDI, 16'h0010));
        send_item(make_step(KIND_EXEC, OP_STX, 16'h0103));
        send_item(make_step(KIND_EXEC, OP_LDX, 16'h0003));
        send_item(make_step(KIND_EXEC, OP_BRZ, 16'h1234));     // not taken
        send_item(make_step(KIND_EXEC, OP_LD, 16'h00AA));      // never written, reads zero
        send_item(make_step(KIND_EXEC, OP_NEG, '0));           // negate zero
        send_item(make_step(KIND_EXEC, OP_BRZ, 16'hFFFF));     // taken, pc at the top
        send_item(make_step(KIND_EXEC, OP_LDI, '0));           // pc not below size
        send_item(make_step(KIND_RETURN, OP_LDI, '0));         // pc wraps to 0
        send_item(make_step(KIND_EXEC, 4'd8, '0));             // lowest illegal opcode
        send_item(make_step(KIND_EXEC, OP_LDI, 16'h5555));     // ignored while pending
        send_item(make_step(KIND_RETURN, OP_LDI, '0));
        send_item(make_step(KIND_EXEC, 4'd15, '0));            // highest illegal opcode
        send_item(make_step(KIND_RETURN, OP_LDI, '0));
        wait_for_results();
    endtask

    initial
    begin : stimulus
        sb          = new();
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_valid    = 1'b0;
        in_item     = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        send_doubling_chain(16'h8000, 16);                 // most negative value, then negate
        wait_for_results();

        run_phase(16'hFFFF, 250, 1'b0, 1'b0);
        run_phase(16'd64, 200, 1'b1, 1'b0);                // back to back on both sides
        run_phase(16'hFFFF, 150, 1'b0, 1'b1);              // receiver holds off, block fills
        run_phase(16'd1, 40, 1'b0, 1'b0);
        run_phase(PC_W'($urandom_range(2, 400)), 200, 1'b0, 1'b0);
        run_phase(16'd0, 30, 1'b1, 1'b0);                  // every execute faults or is ignored while pending
        run_phase(16'hFFFE, 200, 1'b0, 1'b0);

        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
sv/acs_pkg.sv
sv/acs_dmem.sv
sv/accumulator_cpu_step_unit.sv
sim/testbench.sv
